/* sv/sieu_pkg.sv */
// Shared types and constants for the scalar integer execute unit.
// No dependencies; the register file, data memory, top level and testbench refer to it by scoped names.
package sieu_pkg;

   localparam int DATA_BYTES    = 4096;
   localparam int NUM_REGISTERS = 32;
   localparam int AW            = $clog2(DATA_BYTES);
   localparam int ROWS          = DATA_BYTES / 4;
   localparam int RW            = $clog2(ROWS);
   localparam int RIW           = $clog2(NUM_REGISTERS);

   typedef enum logic [5:0] {
      OP_ADD, OP_ADDI, OP_ADDIU, OP_ADDU, OP_AND, OP_ANDI, OP_BEQ, OP_BGEZ,
      OP_BGEZAL, OP_BGTZ, OP_BLEZ, OP_BLTZ, OP_BLTZAL, OP_BNE, OP_BREAK, OP_J,
      OP_JAL, OP_JALR, OP_JR, OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LUI, OP_LW,
      OP_LWU, OP_NOR, OP_OR, OP_ORI, OP_SB, OP_SH, OP_SLL, OP_SLLV, OP_SLT,
      OP_SLTI, OP_SLTIU, OP_SLTU, OP_SRA, OP_SRAV, OP_SRL, OP_SRLV, OP_SUB,
      OP_SUBU, OP_SW, OP_XOR, OP_XORI
   } op_type;

   typedef enum logic [2:0] {LD_NONE, LD_B, LD_BU, LD_H, LD_HU, LD_W} ld_kind_type;
   typedef enum logic [1:0] {ST_NONE, ST_B, ST_H, ST_W} st_kind_type;

   typedef struct packed {
      logic           en;
      logic [RIW-1:0] addr;
      logic [31:0]    data;
   } rf_wr_type;

   typedef struct packed {
      logic          en;
      st_kind_type   st;
      logic [AW-1:0] addr;
      logic [31:0]   data;
      logic          clr;
      logic [RW-1:0] clr_row;
   } dm_req_type;

endpackage

/* sv/sieu_req_if.sv */
// Instruction channel of the scalar integer execute unit.
// Depends on sieu_pkg for nothing but shares its field widths by convention.
interface sieu_req_if;
   logic        valid;
   logic        ready;
   logic [5:0]  req_type;
   logic [4:0]  rs_index;
   logic [4:0]  rt_index;
   logic [4:0]  rd_index;
   logic [4:0]  shift_amount;
   logic [15:0] immediate;
   logic [25:0] jump_index;
   logic [11:0] pc;

   modport source (output valid, req_type, rs_index, rt_index, rd_index, shift_amount,
                   immediate, jump_index, pc, input ready);
   modport sink (input valid, req_type, rs_index, rt_index, rd_index, shift_amount,
                 immediate, jump_index, pc, output ready);
endinterface

/* sv/sieu_rsp_if.sv */
// Result channel of the scalar integer execute unit.
// Standalone; no package dependency.
interface sieu_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_enable;
   logic [4:0]  write_register;
   logic [31:0] write_value;
   logic        branch_taken;
   logic [11:0] branch_target;
   logic        halt;
   logic        raise_interrupt;

   modport source (output valid, write_enable, write_register, write_value, branch_taken,
                   branch_target, halt, raise_interrupt, input ready);
   modport sink (input valid, write_enable, write_register, write_value, branch_taken,
                 branch_target, halt, raise_interrupt, output ready);
endinterface

/* sv/sieu_regfile.sv */
// Register file: synchronous memory with two registered read ports, one write port.
// Depends on sieu_pkg; per-entry valid bits make unwritten entries read as zero.
module sieu_regfile (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [sieu_pkg::RIW-1:0] rd_addr_a,
   input  logic [sieu_pkg::RIW-1:0] rd_addr_b,
   input  sieu_pkg::rf_wr_type      wr,
   output logic [31:0]              rd_data_a,
   output logic [31:0]              rd_data_b
);
   logic [31:0] mem [sieu_pkg::NUM_REGISTERS];
   logic [sieu_pkg::NUM_REGISTERS-1:0] valid_ff;
   logic [31:0] qa_ff, qb_ff;
   logic        va_ff, vb_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         qa_ff <= mem[rd_addr_a];
         qb_ff <= mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         va_ff    <= 1'b0;
         vb_ff    <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            va_ff <= valid_ff[rd_addr_a];
            vb_ff <= valid_ff[rd_addr_b];
         end
      end
   end

   assign rd_data_a = va_ff ? qa_ff : 32'd0;
   assign rd_data_b = vb_ff ? qb_ff : 32'd0;
endmodule

/* sv/sieu_dmem.sv */
// Data memory: four byte banks so an unaligned, wrapping word access needs one access to each bank.
// Depends on sieu_pkg; read data is registered and returned in big-endian byte order.
module sieu_dmem (
   input  logic                clock,
   input  sieu_pkg::dm_req_type req,
   output logic [31:0]         rd_word
);
   logic [7:0] q_ff [4];
   logic [1:0] lo_ff;

   for (genvar j = 0; j < 4; j++) begin : g_bank
      logic [7:0]              bank [sieu_pkg::ROWS];
      logic [1:0]              k;
      logic [sieu_pkg::AW-1:0] baddr;
      logic [sieu_pkg::RW-1:0] row;
      logic [31:0]             sdata;
      logic                    we;
      logic [7:0]              wbyte;

      always_comb begin
         k     = 2'(j) - req.addr[1:0];
         baddr = req.addr + sieu_pkg::AW'(k);
         row   = req.clr ? req.clr_row : baddr[sieu_pkg::AW-1:2];
         unique case (req.st)
            sieu_pkg::ST_W: begin sdata = req.data;                  we = 1'b1;       end
            sieu_pkg::ST_H: begin sdata = {req.data[15:0], 16'd0};   we = (k < 2'd2); end
            sieu_pkg::ST_B: begin sdata = {req.data[7:0], 24'd0};    we = (k == 2'd0); end
            default:        begin sdata = req.data;                  we = 1'b0;       end
         endcase
         wbyte = sdata[31 - 8*k -: 8];
      end

      always_ff @(posedge clock) begin
         if (req.clr) begin
            bank[row] <= 8'd0;
         end else if (req.en && we) begin
            bank[row] <= wbyte;
         end
         if (req.en) begin
            q_ff[j] <= bank[row];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.en) begin
         lo_ff <= req.addr[1:0];
      end
   end

   assign rd_word = {q_ff[lo_ff], q_ff[lo_ff + 2'd1], q_ff[lo_ff + 2'd2], q_ff[lo_ff + 2'd3]};
endmodule

/* sv/scalar_integer_execute_unit.sv */
// Scalar integer execute unit: one decoded instruction per beat, one result beat each.
// An accepted request beat passes the execute stage (register read issued on acceptance), then
// the output stage (data-memory access issued as the beat leaves execute); throughput one beat
// per cycle while results are taken and no clear runs. After reset the data memory is cleared
// row by row: no request beat is taken until every row is cleared. Reset clears all control state.
module scalar_integer_execute_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic          csr_write_data,
   sieu_req_if.sink      req_bus,
   sieu_rsp_if.source    rsp_bus
);
   // Configuration register.
   logic irq_on_break_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         irq_on_break_ff <= 1'b0;
      end else if (csr_write_enable) begin
         irq_on_break_ff <= csr_write_data;
      end
   end

   // Clearing pass over the data memory after reset.
   logic                    clr_busy_ff, clr_busy_in;
   logic [sieu_pkg::RW-1:0] clr_row_ff, clr_row_in;
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_row_in  = clr_row_ff;
      if (clr_busy_ff) begin
         clr_row_in = clr_row_ff + 1'b1;
         if (clr_row_ff == sieu_pkg::RW'(sieu_pkg::ROWS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_row_ff  <= clr_row_in;
      end
   end

   // Pipeline control. The output register advances when empty or taken; the execute
   // stage can still take a beat while the output register holds a stalled result.
   logic out_valid_ff, s1_valid_ff;
   logic advance, req_fire, s1_move;
   assign advance  = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !clr_busy_ff && (advance || !s1_valid_ff);
   assign req_fire = req_bus.valid && req_bus.ready;
   assign s1_move  = s1_valid_ff && advance;

   // Execute stage payload.
   logic [5:0]  s1_op_ff;
   logic [4:0]  s1_rs_ff, s1_rt_ff, s1_rd_ff, s1_sa_ff;
   logic [15:0] s1_imm_ff;
   logic [25:0] s1_jidx_ff;
   logic [11:0] s1_pc_ff;
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff   <= req_bus.req_type;
         s1_rs_ff   <= req_bus.rs_index;
         s1_rt_ff   <= req_bus.rt_index;
         s1_rd_ff   <= req_bus.rd_index;
         s1_sa_ff   <= req_bus.shift_amount;
         s1_imm_ff  <= req_bus.immediate;
         s1_jidx_ff <= req_bus.jump_index;
         s1_pc_ff   <= req_bus.pc;
      end
   end

   // Register file; its read is issued as the request beat is accepted.
   sieu_pkg::rf_wr_type rf_wr;
   logic [31:0] rf_a, rf_b;
   sieu_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_fire),
      .rd_addr_a (req_bus.rs_index),
      .rd_addr_b (req_bus.rt_index),
      .wr        (rf_wr),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b)
   );

   // Output stage registers.
   logic        out_wen_ff, out_taken_ff, out_halt_ff, out_irq_ff, wb_pend_ff;
   logic [4:0]  out_reg_ff;
   logic [31:0] out_val_ff;
   logic [11:0] out_tgt_ff;
   sieu_pkg::ld_kind_type out_ld_ff;
   logic [31:0] dm_word, out_wval;

   // Load data is formatted from the registered memory word.
   always_comb begin
      unique case (out_ld_ff)
         sieu_pkg::LD_B:  out_wval = {{24{dm_word[31]}}, dm_word[31:24]};
         sieu_pkg::LD_BU: out_wval = {24'd0, dm_word[31:24]};
         sieu_pkg::LD_H:  out_wval = {{16{dm_word[31]}}, dm_word[31:16]};
         sieu_pkg::LD_HU: out_wval = {16'd0, dm_word[31:16]};
         sieu_pkg::LD_W:  out_wval = dm_word;
         default:         out_wval = out_val_ff;
      endcase
   end

   // The result writes the register file in its first cycle in the output stage.
   logic wr_fire;
   assign wr_fire   = out_valid_ff && wb_pend_ff;
   assign rf_wr.en   = wr_fire;
   assign rf_wr.addr = out_reg_ff;
   assign rf_wr.data = out_wval;

   // Late-write capture: a write at or after the execute stage's read edge would be
   // missed by the registered read data, so it is kept here for that operand.
   logic        ovr_a_v_ff, ovr_a_v_in, ovr_b_v_ff, ovr_b_v_in;
   logic [31:0] ovr_a_ff, ovr_b_ff;
   logic [4:0]  cur_rs, cur_rt;
   assign cur_rs = req_fire ? req_bus.rs_index : s1_rs_ff;
   assign cur_rt = req_fire ? req_bus.rt_index : s1_rt_ff;
   always_comb begin
      ovr_a_v_in = req_fire ? 1'b0 : ovr_a_v_ff;
      ovr_b_v_in = req_fire ? 1'b0 : ovr_b_v_ff;
      if (wr_fire && out_reg_ff == cur_rs) begin
         ovr_a_v_in = 1'b1;
      end
      if (wr_fire && out_reg_ff == cur_rt) begin
         ovr_b_v_in = 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         ovr_a_v_ff <= 1'b0;
         ovr_b_v_ff <= 1'b0;
      end else begin
         ovr_a_v_ff <= ovr_a_v_in;
         ovr_b_v_ff <= ovr_b_v_in;
      end
      if (wr_fire && out_reg_ff == cur_rs) begin
         ovr_a_ff <= out_wval;
      end
      if (wr_fire && out_reg_ff == cur_rt) begin
         ovr_b_ff <= out_wval;
      end
   end

   // Operand selection: a result waiting to be written wins, then a late write, then
   // the register file. Load results forward straight from the memory word.
   logic [31:0] rs, rt;
   always_comb begin
      priority if (wr_fire && out_reg_ff == s1_rs_ff) rs = out_wval;
      else if (ovr_a_v_ff)                             rs = ovr_a_ff;
      else                                             rs = rf_a;
      priority if (wr_fire && out_reg_ff == s1_rt_ff) rt = out_wval;
      else if (ovr_b_v_ff)                             rt = ovr_b_ff;
      else                                             rt = rf_b;
   end

   // Execute.
   logic [31:0] simm, zimm, c_val;
   logic [11:0] btgt, jtgt, link, c_tgt;
   logic        c_wen, c_taken, c_halt, c_irq, wen;
   logic [4:0]  c_reg;
   sieu_pkg::ld_kind_type c_ld;
   sieu_pkg::st_kind_type c_st;
   logic [31:0] addr_sum;

   assign simm     = {{16{s1_imm_ff[15]}}, s1_imm_ff};
   assign zimm     = {16'd0, s1_imm_ff};
   assign btgt     = s1_pc_ff + 12'd4 + {s1_imm_ff[9:0], 2'b00};
   assign jtgt     = {s1_jidx_ff[9:0], 2'b00};
   assign link     = s1_pc_ff + 12'd8;
   assign addr_sum = rs + simm;

   always_comb begin
      c_wen = 1'b0; c_reg = s1_rd_ff; c_val = 32'd0;
      c_taken = 1'b0; c_tgt = btgt; c_halt = 1'b0; c_irq = 1'b0;
      c_ld = sieu_pkg::LD_NONE; c_st = sieu_pkg::ST_NONE;
      unique case (sieu_pkg::op_type'(s1_op_ff))
         sieu_pkg::OP_ADD, sieu_pkg::OP_ADDU: begin c_wen = 1'b1; c_val = rs + rt; end
         sieu_pkg::OP_SUB, sieu_pkg::OP_SUBU: begin c_wen = 1'b1; c_val = rs - rt; end
         sieu_pkg::OP_ADDI, sieu_pkg::OP_ADDIU: begin
            c_wen = 1'b1; c_reg = s1_rt_ff; c_val = addr_sum;
         end
         sieu_pkg::OP_AND: begin c_wen = 1'b1; c_val = rs & rt; end
         sieu_pkg::OP_OR:  begin c_wen = 1'b1; c_val = rs | rt; end
         sieu_pkg::OP_XOR: begin c_wen = 1'b1; c_val = rs ^ rt; end
         sieu_pkg::OP_NOR: begin c_wen = 1'b1; c_val = ~(rs | rt); end
         sieu_pkg::OP_ANDI: begin c_wen = 1'b1; c_reg = s1_rt_ff; c_val = rs & zimm; end
         sieu_pkg::OP_ORI:  begin c_wen = 1'b1; c_reg = s1_rt_ff; c_val = rs | zimm; end
         sieu_pkg::OP_XORI: begin c_wen = 1'b1; c_reg = s1_rt_ff; c_val = rs ^ zimm; end
         sieu_pkg::OP_LUI: begin
            c_wen = 1'b1; c_reg = s1_rt_ff; c_val = {s1_imm_ff, 16'd0};
         end
         sieu_pkg::OP_SLL: begin c_wen = 1'b1; c_val = rt << s1_sa_ff; end
         sieu_pkg::OP_SRL: begin c_wen = 1'b1; c_val = rt >> s1_sa_ff; end
         sieu_pkg::OP_SRA: begin c_wen = 1'b1; c_val = 32'($signed(rt) >>> s1_sa_ff); end
         sieu_pkg::OP_SLLV: begin c_wen = 1'b1; c_val = rt << rs[4:0]; end
         sieu_pkg::OP_SRLV: begin c_wen = 1'b1; c_val = rt >> rs[4:0]; end
         sieu_pkg::OP_SRAV: begin c_wen = 1'b1; c_val = 32'($signed(rt) >>> rs[4:0]); end
         sieu_pkg::OP_SLT: begin c_wen = 1'b1; c_val = {31'd0, $signed(rs) < $signed(rt)}; end
         sieu_pkg::OP_SLTU: begin c_wen = 1'b1; c_val = {31'd0, rs < rt}; end
         sieu_pkg::OP_SLTI: begin
            c_wen = 1'b1; c_reg = s1_rt_ff; c_val = {31'd0, $signed(rs) < $signed(simm)};
         end
         sieu_pkg::OP_SLTIU: begin
            c_wen = 1'b1; c_reg = s1_rt_ff; c_val = {31'd0, rs < simm};
         end
         sieu_pkg::OP_LB:  begin c_wen = 1'b1; c_reg = s1_rt_ff; c_ld = sieu_pkg::LD_B;  end
         sieu_pkg::OP_LBU: begin c_wen = 1'b1; c_reg = s1_rt_ff; c_ld = sieu_pkg::LD_BU; end
         sieu_pkg::OP_LH:  begin c_wen = 1'b1; c_reg = s1_rt_ff; c_ld = sieu_pkg::LD_H;  end
         sieu_pkg::OP_LHU: begin c_wen = 1'b1; c_reg = s1_rt_ff; c_ld = sieu_pkg::LD_HU; end
         sieu_pkg::OP_LW, sieu_pkg::OP_LWU: begin
            c_wen = 1'b1; c_reg = s1_rt_ff; c_ld = sieu_pkg::LD_W;
         end
         sieu_pkg::OP_SB: c_st = sieu_pkg::ST_B;
         sieu_pkg::OP_SH: c_st = sieu_pkg::ST_H;
         sieu_pkg::OP_SW: c_st = sieu_pkg::ST_W;
         sieu_pkg::OP_BEQ:  c_taken = (rs == rt);
         sieu_pkg::OP_BNE:  c_taken = (rs != rt);
         sieu_pkg::OP_BGEZ: c_taken = !rs[31];
         sieu_pkg::OP_BLTZ: c_taken = rs[31];
         sieu_pkg::OP_BGTZ: c_taken = !rs[31] && (rs != 32'd0);
         sieu_pkg::OP_BLEZ: c_taken = rs[31] || (rs == 32'd0);
         sieu_pkg::OP_BGEZAL: begin
            c_taken = !rs[31]; c_wen = 1'b1; c_reg = 5'd31; c_val = {20'd0, link};
         end
         sieu_pkg::OP_BLTZAL: begin
            c_taken = rs[31]; c_wen = 1'b1; c_reg = 5'd31; c_val = {20'd0, link};
         end
         sieu_pkg::OP_J: begin c_taken = 1'b1; c_tgt = jtgt; end
         sieu_pkg::OP_JAL: begin
            c_taken = 1'b1; c_tgt = jtgt; c_wen = 1'b1; c_reg = 5'd31; c_val = {20'd0, link};
         end
         sieu_pkg::OP_JR: begin c_taken = 1'b1; c_tgt = rs[11:0]; end
         sieu_pkg::OP_JALR: begin
            c_taken = 1'b1; c_tgt = rs[11:0]; c_wen = 1'b1; c_val = {20'd0, link};
         end
         sieu_pkg::OP_BREAK: begin c_halt = 1'b1; c_irq = irq_on_break_ff; end
         default: ;
      endcase
   end

   // A write to register zero is dropped entirely.
   assign wen = c_wen && (c_reg != 5'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         wb_pend_ff   <= 1'b0;
      end else begin
         if (advance) begin
            out_valid_ff <= s1_valid_ff;
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            wb_pend_ff <= wen;
         end else if (wr_fire) begin
            wb_pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_wen_ff   <= wen;
         out_reg_ff   <= wen ? c_reg : 5'd0;
         out_val_ff   <= wen ? c_val : 32'd0;
         out_ld_ff    <= wen ? c_ld : sieu_pkg::LD_NONE;
         out_taken_ff <= c_taken;
         out_tgt_ff   <= c_taken ? c_tgt : 12'd0;
         out_halt_ff  <= c_halt;
         out_irq_ff   <= c_irq;
      end
   end

   // Data memory: stores write and loads read as the beat leaves the execute stage.
   sieu_pkg::dm_req_type dm_req;
   always_comb begin
      dm_req.en      = s1_move;
      dm_req.st      = c_st;
      dm_req.addr    = addr_sum[sieu_pkg::AW-1:0];
      dm_req.data    = rt;
      dm_req.clr     = clr_busy_ff;
      dm_req.clr_row = clr_row_ff;
   end
   sieu_dmem u_dmem (
      .clock   (clock),
      .req     (dm_req),
      .rd_word (dm_word)
   );

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.write_enable    = out_wen_ff;
   assign rsp_bus.write_register  = out_reg_ff;
   assign rsp_bus.write_value     = out_wval;
   assign rsp_bus.branch_taken    = out_taken_ff;
   assign rsp_bus.branch_target   = out_tgt_ff;
   assign rsp_bus.halt            = out_halt_ff;
   assign rsp_bus.raise_interrupt = out_irq_ff;

   a_no_beat_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_bus.ready)
      else $error("request beat taken during memory clear");
   a_single_writeback: assert property (@(posedge clock) disable iff (reset)
      wr_fire && !s1_move |=> !wb_pend_ff)
      else $error("result written back twice");
   a_no_write_to_zero: assert property (@(posedge clock) disable iff (reset)
      wr_fire |-> out_reg_ff != 5'd0)
      else $error("write to register zero");
   a_irq_needs_halt: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_irq_ff |-> out_halt_ff)
      else $error("interrupt without break");
endmodule

/* dv/scalar_integer_execute_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the scalar integer execute unit.
// Depends on sieu_pkg, sieu_req_if, sieu_rsp_if and the block's top level.
module scalar_integer_execute_unit_tb;

   // One expected result beat, held in arrival order.
   typedef struct packed {
      logic        wen;
      logic [4:0]  wreg;
      logic [31:0] wval;
      logic        taken;
      logic [11:0] target;
      logic        halt;
      logic        irq;
   } outcome_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   sieu_req_if req_bus ();
   sieu_rsp_if rsp_bus ();

   scalar_integer_execute_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus.sink),
      .rsp_bus          (rsp_bus.source)
   );

   // The predictor keeps its own copy of the architectural state.
   logic [31:0] shadow_regs [sieu_pkg::NUM_REGISTERS];
   logic [7:0]  shadow_mem  [sieu_pkg::DATA_BYTES];
   logic        break_irq_enable;
   outcome_type pending_outcomes [$];

   int error_count;
   int idle_cycles;
   // Sender idles with a chance of send_idle_pct percent before each beat; receiver stalls likewise.
   int send_idle_pct;
   int recv_stall_pct;
   // Set while the receiver is held off for a long stretch.
   bit recv_hold;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] read_reg(logic [4:0] idx);
      return (idx == 5'd0) ? 32'd0 : shadow_regs[idx];
   endfunction

   // Execute one instruction against the shadow state and return the result beat.
   function automatic outcome_type execute_instruction(
      logic [5:0] opc, logic [4:0] rsi, logic [4:0] rti, logic [4:0] rdi,
      logic [4:0] sa, logic [15:0] imm, logic [25:0] jidx, logic [11:0] pc);
      outcome_type o;
      logic [31:0] rs, rt, simm, zimm, val;
      logic [11:0] addr, btgt, link;
      logic [4:0] dst;
      logic wr;
      rs = read_reg(rsi);
      rt = read_reg(rti);
      simm = {{16{imm[15]}}, imm};
      zimm = {16'd0, imm};
      addr = 12'(rs + simm);
      btgt = 12'(pc + 12'd4 + 12'(simm << 2));
      link = 12'(pc + 12'd8);
      o = '0;
      wr = 1'b0;
      dst = 5'd0;
      val = 32'd0;
      unique case (opc)
         sieu_pkg::OP_ADD, sieu_pkg::OP_ADDU: begin wr = 1; dst = rdi; val = rs + rt; end
         sieu_pkg::OP_SUB, sieu_pkg::OP_SUBU: begin wr = 1; dst = rdi; val = rs - rt; end
         sieu_pkg::OP_ADDI, sieu_pkg::OP_ADDIU: begin wr = 1; dst = rti; val = rs + simm; end
         sieu_pkg::OP_AND: begin wr = 1; dst = rdi; val = rs & rt; end
         sieu_pkg::OP_OR: begin wr = 1; dst = rdi; val = rs | rt; end
         sieu_pkg::OP_XOR: begin wr = 1; dst = rdi; val = rs ^ rt; end
         sieu_pkg::OP_NOR: begin wr = 1; dst = rdi; val = ~(rs | rt); end
         sieu_pkg::OP_ANDI: begin wr = 1; dst = rti; val = rs & zimm; end
         sieu_pkg::OP_ORI: begin wr = 1; dst = rti; val = rs | zimm; end
         sieu_pkg::OP_XORI: begin wr = 1; dst = rti; val = rs ^ zimm; end
         sieu_pkg::OP_LUI: begin wr = 1; dst = rti; val = {imm, 16'd0}; end
         sieu_pkg::OP_SLL: begin wr = 1; dst = rdi; val = rt << sa; end
         sieu_pkg::OP_SRL: begin wr = 1; dst = rdi; val = rt >> sa; end
         sieu_pkg::OP_SRA: begin wr = 1; dst = rdi; val = $signed(rt) >>> sa; end
         sieu_pkg::OP_SLLV: begin wr = 1; dst = rdi; val = rt << rs[4:0]; end
         sieu_pkg::OP_SRLV: begin wr = 1; dst = rdi; val = rt >> rs[4:0]; end
         sieu_pkg::OP_SRAV: begin wr = 1; dst = rdi; val = $signed(rt) >>> rs[4:0]; end
         sieu_pkg::OP_SLT: begin
            wr = 1; dst = rdi; val = {31'd0, $signed(rs) < $signed(rt)};
         end
         sieu_pkg::OP_SLTU: begin wr = 1; dst = rdi; val = {31'd0, rs < rt}; end
         sieu_pkg::OP_SLTI: begin
            wr = 1; dst = rti; val = {31'd0, $signed(rs) < $signed(simm)};
         end
         sieu_pkg::OP_SLTIU: begin wr = 1; dst = rti; val = {31'd0, rs < simm}; end
         sieu_pkg::OP_LB, sieu_pkg::OP_LBU: begin
            wr = 1; dst = rti;
            val = {24'd0, shadow_mem[addr]};
            if (opc == sieu_pkg::OP_LB && val[7]) val[31:8] = '1;
         end
         sieu_pkg::OP_LH, sieu_pkg::OP_LHU: begin
            wr = 1; dst = rti;
            val = {16'd0, shadow_mem[addr], shadow_mem[12'(addr + 1)]};
            if (opc == sieu_pkg::OP_LH && val[15]) val[31:16] = '1;
         end
         sieu_pkg::OP_LW, sieu_pkg::OP_LWU: begin
            wr = 1; dst = rti;
            val = {shadow_mem[addr], shadow_mem[12'(addr + 1)],
                   shadow_mem[12'(addr + 2)], shadow_mem[12'(addr + 3)]};
         end
         // Each byte of a store wraps around the memory on its own.
         sieu_pkg::OP_SB: shadow_mem[addr] = rt[7:0];
         sieu_pkg::OP_SH: begin
            shadow_mem[addr] = rt[15:8];
            shadow_mem[12'(addr + 1)] = rt[7:0];
         end
         sieu_pkg::OP_SW: begin
            shadow_mem[addr] = rt[31:24];
            shadow_mem[12'(addr + 1)] = rt[23:16];
            shadow_mem[12'(addr + 2)] = rt[15:8];
            shadow_mem[12'(addr + 3)] = rt[7:0];
         end
         sieu_pkg::OP_BEQ: begin o.taken = (rs == rt); o.target = btgt; end
         sieu_pkg::OP_BNE: begin o.taken = (rs != rt); o.target = btgt; end
         sieu_pkg::OP_BGEZ: begin o.taken = !rs[31]; o.target = btgt; end
         sieu_pkg::OP_BLTZ: begin o.taken = rs[31]; o.target = btgt; end
         sieu_pkg::OP_BGTZ: begin o.taken = !rs[31] && rs != 0; o.target = btgt; end
         sieu_pkg::OP_BLEZ: begin o.taken = rs[31] || rs == 0; o.target = btgt; end
         // The linking branches write r31 whether or not they are taken.
         sieu_pkg::OP_BGEZAL: begin
            o.taken = !rs[31]; o.target = btgt;
            wr = 1; dst = 5'd31; val = {20'd0, link};
         end
         sieu_pkg::OP_BLTZAL: begin
            o.taken = rs[31]; o.target = btgt;
            wr = 1; dst = 5'd31; val = {20'd0, link};
         end
         sieu_pkg::OP_J: begin o.taken = 1; o.target = {jidx[9:0], 2'b00}; end
         sieu_pkg::OP_JAL: begin
            o.taken = 1; o.target = {jidx[9:0], 2'b00};
            wr = 1; dst = 5'd31; val = {20'd0, link};
         end
         sieu_pkg::OP_JR: begin o.taken = 1; o.target = rs[11:0]; end
         // The jump target uses rs as read before the link is written.
         sieu_pkg::OP_JALR: begin
            o.taken = 1; o.target = rs[11:0];
            wr = 1; dst = rdi; val = {20'd0, link};
         end
         sieu_pkg::OP_BREAK: begin o.halt = 1; o.irq = break_irq_enable; end
         default: ;
      endcase
      if (!o.taken) o.target = 12'd0;
      if (wr && dst != 5'd0) begin
         shadow_regs[dst] = val;
         o.wen = 1'b1;
         o.wreg = dst;
         o.wval = val;
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Send one instruction beat; the prediction is made when it is accepted.
   task automatic send_instruction(logic [5:0] opc, logic [4:0] rsi, logic [4:0] rti,
                                   logic [4:0] rdi, logic [4:0] sa, logic [15:0] imm,
                                   logic [25:0] jidx, logic [11:0] pc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= opc;
      req_bus.rs_index     <= rsi;
      req_bus.rt_index     <= rti;
      req_bus.rd_index     <= rdi;
      req_bus.shift_amount <= sa;
      req_bus.immediate    <= imm;
      req_bus.jump_index   <= jidx;
      req_bus.pc           <= pc;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_outcomes.push_back(execute_instruction(opc, rsi, rti, rdi, sa, imm, jidx, pc));
   endtask

   task automatic go_quiet();
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      // Margin after the last result beat.
      repeat (4) @(posedge clock);
   endtask

   task automatic write_break_irq(logic value);
      go_quiet();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      break_irq_enable = value;
   endtask

   task automatic send_random_instruction(bit mem_focus);
      logic [5:0] opc;
      logic [15:0] imm;
      logic [4:0] rsi;
      opc = 6'($urandom_range(mem_focus ? 50 : 63));
      if (mem_focus && $urandom_range(1))
         opc = ($urandom_range(1)) ? sieu_pkg::OP_SW : sieu_pkg::OP_LW;
      if (opc > sieu_pkg::OP_XORI && $urandom_range(3) != 0)
         opc = 6'($urandom_range(sieu_pkg::OP_XORI));
      imm = 16'($urandom);
      rsi = 5'($urandom);
      // Memory traffic mostly near small addresses so loads see earlier stores.
      if (mem_focus) begin
         imm = 16'($urandom_range(40));
         if ($urandom_range(3) == 0) imm = 16'hFFFF - 16'($urandom_range(8));
         rsi = 5'd0;
      end
      send_instruction(opc, rsi, 5'($urandom), 5'($urandom), 5'($urandom), imm,
                       26'($urandom), 12'($urandom));
   endtask

   // Extremes of every field, a chosen set of operations and a random pick of all operations, with r0 handling.
   task automatic test_directed();
      send_instruction(sieu_pkg::OP_LUI, 5'd0, 5'd1, 5'd0, 5'd0, 16'hFFFF, '0, '0);
      send_instruction(sieu_pkg::OP_ORI, 5'd1, 5'd1, 5'd0, 5'd0, 16'hFFFF, '0, '0);
      send_instruction(sieu_pkg::OP_LUI, 5'd0, 5'd2, 5'd0, 5'd0, 16'h8000, '0, '0);
      send_instruction(sieu_pkg::OP_ADDI, 5'd0, 5'd0, 5'd0, 5'd0, 16'h1234, '0, '0);
      send_instruction(sieu_pkg::OP_ADD, 5'd1, 5'd2, 5'd3, 5'd0, '0, '0, '0);
      send_instruction(sieu_pkg::OP_SRA, 5'd0, 5'd2, 5'd4, 5'd31, '0, '0, '0);
      send_instruction(sieu_pkg::OP_SLLV, 5'd1, 5'd1, 5'd5, 5'd0, '0, '0, '0);
      send_instruction(sieu_pkg::OP_SLT, 5'd2, 5'd1, 5'd6, 5'd0, '0, '0, '0);
      send_instruction(sieu_pkg::OP_SLTIU, 5'd1, 5'd7, 5'd0, 5'd0, 16'hFFFF, '0, '0);
      // A word store that wraps off the top of memory, then its readback.
      send_instruction(sieu_pkg::OP_SW, 5'd0, 5'd2, 5'd0, 5'd0, 16'hFFFE, '0, '0);
      send_instruction(sieu_pkg::OP_LW, 5'd0, 5'd8, 5'd0, 5'd0, 16'hFFFE, '0, '0);
      send_instruction(sieu_pkg::OP_LH, 5'd0, 5'd9, 5'd0, 5'd0, 16'hFFFF, '0, '0);
      send_instruction(sieu_pkg::OP_LB, 5'd0, 5'd10, 5'd0, 5'd0, 16'hFFFE, '0, '0);
      send_instruction(sieu_pkg::OP_BLTZAL, 5'd1, 5'd0, 5'd0, 5'd0, 16'h8000, '0, 12'hFFF);
      send_instruction(sieu_pkg::OP_BGEZAL, 5'd1, 5'd0, 5'd0, 5'd0, 16'h7FFF, '0, 12'hFFC);
      send_instruction(sieu_pkg::OP_JAL, 5'd0, 5'd0, 5'd0, 5'd0, '0, 26'h3FFFFFF, 12'hFFF);
      send_instruction(sieu_pkg::OP_JALR, 5'd31, 5'd0, 5'd31, 5'd0, '0, '0, 12'h800);
      send_instruction(sieu_pkg::OP_BREAK, 5'd0, 5'd0, 5'd0, 5'd0, '0, '0, '0);
      send_instruction(6'd63, 5'd31, 5'd31, 5'd31, 5'd31, 16'hFFFF, 26'h3FFFFFF, 12'hFFF);
      for (int k = 0; k <= sieu_pkg::OP_XORI; k++)
         if ($urandom_range(3) == 0)
            send_instruction(6'(k), 5'($urandom), 5'($urandom), 5'($urandom),
                             5'($urandom), 16'($urandom), 26'($urandom), 12'($urandom));
   endtask

   task automatic test_break_interrupt();
      write_break_irq(1'b1);
      send_instruction(sieu_pkg::OP_BREAK, 5'd0, 5'd0, 5'd0, 5'd0, '0, '0, '0);
      for (int k = 0; k < 30; k++) send_random_instruction(0);
      write_break_irq(1'b0);
      send_instruction(sieu_pkg::OP_BREAK, 5'd0, 5'd0, 5'd0, 5'd0, '0, '0, '0);
   endtask

   task automatic test_random_phases();
      int idle_mix [4][2] = '{'{0, 0}, '{80, 0}, '{0, 80}, '{27, 27}};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_mix[p][0];
         recv_stall_pct = idle_mix[p][1];
         for (int k = 0; k < 250; k++) send_random_instruction(k % 3 == 0);
         if (p == 1) write_break_irq(1'b1);
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   // The receiver holds off long enough that the block stalls its input.
   task automatic test_backpressure();
      fork
         begin
            recv_hold = 1'b1;
            repeat (60) @(posedge clock);
            recv_hold = 1'b0;
         end
         for (int k = 0; k < 50; k++) send_random_instruction(1);
      join
   endtask

   // Result checker and receiver readiness.
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch("unexpected beat", 32'd0, 32'd0);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_bus.write_enable !== want.wen)
                  report_mismatch("write_enable", rsp_bus.write_enable, want.wen);
               if (rsp_bus.write_register !== want.wreg)
                  report_mismatch("write_register", rsp_bus.write_register, want.wreg);
               if (rsp_bus.write_value !== want.wval)
                  report_mismatch("write_value", rsp_bus.write_value, want.wval);
               if (rsp_bus.branch_taken !== want.taken)
                  report_mismatch("branch_taken", rsp_bus.branch_taken, want.taken);
               if (rsp_bus.branch_target !== want.target)
                  report_mismatch("branch_target", rsp_bus.branch_target, want.target);
               if (rsp_bus.halt !== want.halt)
                  report_mismatch("halt", rsp_bus.halt, want.halt);
               if (rsp_bus.raise_interrupt !== want.irq)
                  report_mismatch("raise_interrupt", rsp_bus.raise_interrupt, want.irq);
            end
         end
         if (recv_hold) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: counts cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("scalar_integer_execute_unit_tb: FAIL");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.req_type = '0;
      req_bus.rs_index = '0;
      req_bus.rt_index = '0;
      req_bus.rd_index = '0;
      req_bus.shift_amount = '0;
      req_bus.immediate = '0;
      req_bus.jump_index = '0;
      req_bus.pc = '0;
      rsp_bus.ready = 1'b0;
      error_count = 0;
      idle_cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      recv_hold = 1'b0;
      break_irq_enable = 1'b0;
      foreach (shadow_regs[k]) shadow_regs[k] = '0;
      foreach (shadow_mem[k]) shadow_mem[k] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_break_interrupt();
      test_random_phases();
      test_backpressure();
      go_quiet();

      if (error_count == 0)
         $display("scalar_integer_execute_unit_tb: PASS");
      else
         $display("scalar_integer_execute_unit_tb: FAIL");
      $finish;
   end

endmodule
